FILE: rtl/hood_pkg.sv
`default_nettype none

package hood_pkg;

    localparam int MAX_VEL_CHANNELS = 4;
    localparam int NUM_VEL_CHANNELS = 4;
    localparam int NUM_LANES        = NUM_VEL_CHANNELS + 1;
    localparam int MAX_LANES        = MAX_VEL_CHANNELS + 1;

    localparam int Q15_W  = 15;
    localparam int THR_W  = 14;
    localparam int BASE_W = 15;
    localparam int VEL_W  = 16;
    localparam int CFG_W  = 15;

    localparam logic [THR_W-1:0]  THRESHOLD_RESET  = THR_W'(8192);
    localparam logic [BASE_W-1:0] BASE_RATIO_RESET = BASE_W'(19661);

    typedef logic [Q15_W-1:0] t_q15;

    typedef enum logic {
        CFG_THRESHOLD  = 1'b0,
        CFG_BASE_RATIO = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_ONSET  = 2'd1,
        EV_OFFSET = 2'd2
    } t_event;

    typedef struct packed {
        logic        [Q15_W-1:0] magnitude;
        logic signed [VEL_W-1:0] velocity_0;
        logic signed [VEL_W-1:0] velocity_1;
        logic signed [VEL_W-1:0] velocity_2;
        logic signed [VEL_W-1:0] velocity_3;
    } t_in;

    typedef struct packed {
        logic [1:0] event_mag;
        logic [1:0] event_vel_0;
        logic [1:0] event_vel_1;
        logic [1:0] event_vel_2;
        logic [1:0] event_vel_3;
        logic       active_mag;
        logic       active_vel_0;
        logic       active_vel_1;
        logic       active_vel_2;
        logic       active_vel_3;
    } t_out;

endpackage

`default_nettype wire

FILE: rtl/hood_prep.sv
`default_nettype none

module hood_prep
    import hood_pkg::*;
(
    input  wire                i_clk,
    input  wire                i_en,
    input  t_in                i_data,
    input  wire  [BASE_W-1:0]  i_base_ratio,
    output t_q15               o_val [NUM_LANES],
    output t_q15               o_floor
);

    logic signed [VEL_W-1:0]     vel [MAX_VEL_CHANNELS];
    t_q15                        n_val [NUM_LANES];
    logic [Q15_W+BASE_W-1:0]     prod;
    t_q15                        r_val [NUM_LANES];
    t_q15                        r_floor;

    assign vel[0] = i_data.velocity_0;
    assign vel[1] = i_data.velocity_1;
    assign vel[2] = i_data.velocity_2;
    assign vel[3] = i_data.velocity_3;

    assign prod = (Q15_W+BASE_W)'(i_data.magnitude) * (Q15_W+BASE_W)'(i_base_ratio);

    always_comb begin
        n_val[0] = i_data.magnitude;
        for (int c = 0; c < NUM_VEL_CHANNELS; c++) begin
            if (!vel[c][VEL_W-1]) begin
                n_val[c+1] = vel[c][Q15_W-1:0];
            end else if (vel[c] == {1'b1, {(VEL_W-1){1'b0}}}) begin
                // most negative value saturates
                n_val[c+1] = {Q15_W{1'b1}};
            end else begin
                n_val[c+1] = Q15_W'(-vel[c]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_val   <= n_val;
            r_floor <= prod[Q15_W+BASE_W-1:BASE_W];
        end
    end

    assign o_val   = r_val;
    assign o_floor = r_floor;

endmodule

`default_nettype wire

FILE: rtl/hood_lane.sv
`default_nettype none

module hood_lane
    import hood_pkg::*;
(
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_en,
    input  t_q15              i_val,
    input  t_q15              i_floor,
    input  wire  [THR_W-1:0]  i_threshold,
    output t_event            o_event,
    output logic              o_active
);

    logic                 r_active, n_active;
    t_q15                 r_low, n_low;
    t_q15                 r_high, n_high;
    t_q15                 low_m, high_m;
    logic [Q15_W:0]       rise_level;
    logic [Q15_W+THR_W-1:0] rel_prod;
    logic [THR_W-1:0]     rel_level;
    t_event               ev;

    always_comb begin
        low_m      = (i_val < r_low) ? i_val : r_low;
        high_m     = (i_val > r_high) ? i_val : r_high;
        rise_level = {1'b0, low_m} + (Q15_W+1)'(i_threshold);
        rel_prod   = (Q15_W+THR_W)'(high_m) * (Q15_W+THR_W)'(i_threshold);
        rel_level  = rel_prod[Q15_W+THR_W-1:Q15_W];
    end

    // an onset can not release in the same transaction: threshold < 0.5 in Q1.15
    always_comb begin
        n_active = r_active;
        n_low    = r_low;
        n_high   = r_high;
        ev       = EV_NONE;
        if (!r_active) begin
            n_low = low_m;
            if (({1'b0, i_val} > rise_level) && (i_val > i_floor)) begin
                ev       = EV_ONSET;
                n_active = 1'b1;
                n_high   = i_val;
            end
        end else begin
            n_high = high_m;
            if (i_val < {1'b0, rel_level}) begin
                ev       = EV_OFFSET;
                n_active = 1'b0;
                n_low    = i_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_low    <= '0;
            r_high   <= '0;
        end else if (i_en) begin
            r_active <= n_active;
            r_low    <= n_low;
            r_high   <= n_high;
        end
    end

    assign o_event  = ev;
    assign o_active = n_active;

endmodule

`default_nettype wire

FILE: rtl/hysteresis_onset_offset_detector_core.sv
// Hysteresis onset/offset detector, one frame per transaction.
// Input channel (i_valid/o_ready, i_data): magnitude in unsigned Q0.15 and
// four signed velocity components in Q1.15. Output channel (o_valid/i_ready,
// o_data): per channel event code (none/onset/offset) and active flag.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx
// (0 threshold, 1 base_ratio) at the clock edge; write only while idle.
// Throughput: one transaction per cycle while the receiver does not stall.
// Stage one registers magnitude * base_ratio and the saturated absolute
// velocities; stage two runs one lane per channel, each doing a single
// 15x14 multiply for the release level, and merges the lane results into
// the output register, which drives o_valid.
// A stalled receiver holds the output register; the pipeline keeps
// accepting until both stages are full, so o_ready depends on i_ready.
// Synchronous active-low reset clears the pipeline valids, all channel
// state (idle, minimum and maximum zero) and restores register defaults.
`default_nettype none

module hysteresis_onset_offset_detector_core
    import hood_pkg::*;
(
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    output logic              o_ready,
    input  t_in               i_data,
    output logic              o_valid,
    input  wire               i_ready,
    output t_out              o_data,
    input  wire               i_cfg_we,
    input  t_cfg_idx          i_cfg_idx,
    input  wire  [CFG_W-1:0]  i_cfg_data
);

    logic [THR_W-1:0]  r_threshold;
    logic [BASE_W-1:0] r_base_ratio;
    logic              r_s1_valid;
    logic              r_out_valid;
    t_out              r_out, n_out;
    logic              out_en;
    logic              in_en;
    logic              lane_en;
    t_q15              val [NUM_LANES];
    t_q15              floor_level;
    t_event            ev [MAX_LANES];
    logic              act [MAX_LANES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold  <= THRESHOLD_RESET;
            r_base_ratio <= BASE_RATIO_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_THRESHOLD:  r_threshold  <= i_cfg_data[THR_W-1:0];
                CFG_BASE_RATIO: r_base_ratio <= i_cfg_data[BASE_W-1:0];
            endcase
        end
    end

    assign out_en  = !r_out_valid || i_ready;
    assign o_ready = !r_s1_valid || out_en;
    assign in_en   = i_valid && o_ready;
    assign lane_en = r_s1_valid && out_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_s1_valid <= i_valid;
            end
            if (out_en) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    hood_prep u_prep (
        .i_clk        (i_clk),
        .i_en         (in_en),
        .i_data       (i_data),
        .i_base_ratio (r_base_ratio),
        .o_val        (val),
        .o_floor      (floor_level)
    );

    for (genvar c = 0; c < MAX_LANES; c++) begin : g_lane
        if (c < NUM_LANES) begin : g_on
            hood_lane u_lane (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_en        (lane_en),
                .i_val       (val[c]),
                .i_floor     (floor_level),
                .i_threshold (r_threshold),
                .o_event     (ev[c]),
                .o_active    (act[c])
            );
        end else begin : g_off
            assign ev[c]  = EV_NONE;
            assign act[c] = 1'b0;
        end
    end

    always_comb begin
        n_out.event_mag    = ev[0];
        n_out.event_vel_0  = ev[1];
        n_out.event_vel_1  = ev[2];
        n_out.event_vel_2  = ev[3];
        n_out.event_vel_3  = ev[4];
        n_out.active_mag   = act[0];
        n_out.active_vel_0 = act[1];
        n_out.active_vel_1 = act[2];
        n_out.active_vel_2 = act[3];
        n_out.active_vel_3 = act[4];
    end

    always_ff @(posedge i_clk) begin
        if (lane_en) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

`default_nettype wire

FILE: tb/hysteresis_onset_offset_detector_core_test.sv
`timescale 1ns / 1ps

module hysteresis_onset_offset_detector_core_test
    import hood_pkg::*;
();

    localparam int LIMIT_CYCLES  = 600000;
    localparam int SETTLE_CYCLES = 6;

    logic             i_clk      = 1'b0;
    logic             i_rst_n    = 1'b0;
    logic             i_valid    = 1'b0;
    logic             o_ready;
    t_in              i_data     = '0;
    logic             o_valid;
    logic             i_ready    = 1'b0;
    t_out             o_data;
    logic             i_cfg_we   = 1'b0;
    t_cfg_idx         i_cfg_idx  = CFG_THRESHOLD;
    logic [CFG_W-1:0] i_cfg_data = '0;

    hysteresis_onset_offset_detector_core uut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_data    (i_data),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_data    (o_data),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    initial forever #1 i_clk = ~i_clk;

    // detector state as the block should hold it
    logic [THR_W-1:0]  thr_cfg  = THRESHOLD_RESET;
    logic [BASE_W-1:0] base_cfg = BASE_RATIO_RESET;
    logic              lane_active [MAX_LANES];
    logic [Q15_W-1:0]  lane_min    [MAX_LANES];
    logic [Q15_W-1:0]  lane_max    [MAX_LANES];

    t_out pending_events[$];
    int   walk_lvl [MAX_LANES];
    int   fail_count   = 0;
    int   frames_sent  = 0;
    int   results_seen = 0;
    int   onsets_seen  = 0;
    int   offsets_seen = 0;
    int   cycle_count  = 0;
    int   rx_hold      = 0;
    bit   tx_steady    = 1'b0;
    bit   rx_steady    = 1'b0;

    initial begin
        for (int c = 0; c < MAX_LANES; c++) begin
            lane_active[c] = 1'b0;
            lane_min[c]    = '0;
            lane_max[c]    = '0;
            walk_lvl[c]    = 0;
        end
    end

    function automatic logic [Q15_W-1:0] abs_clip(input logic signed [VEL_W-1:0] v);
        if (!v[VEL_W-1])
            return v[Q15_W-1:0];
        if (v == {1'b1, {(VEL_W-1){1'b0}}})
            return '1;
        return Q15_W'(-v);
    endfunction

    function automatic t_event step_lane(input int c, input logic [Q15_W-1:0] val,
                                         input logic [Q15_W-1:0] floor_lvl);
        t_event                 ev;
        logic [Q15_W:0]         rise;
        logic [Q15_W+THR_W-1:0] rel_prod;
        ev = EV_NONE;
        if (!lane_active[c]) begin
            if (val < lane_min[c])
                lane_min[c] = val;
            rise = lane_min[c] + thr_cfg;
            if (val > rise && val > floor_lvl) begin
                ev             = EV_ONSET;
                lane_active[c] = 1'b1;
                lane_max[c]    = val;
            end
        end
        // release test also runs in the onset frame
        if (lane_active[c]) begin
            if (val > lane_max[c])
                lane_max[c] = val;
            rel_prod = lane_max[c] * thr_cfg;
            if (val < (rel_prod >> 15)) begin
                ev             = EV_OFFSET;
                lane_active[c] = 1'b0;
                lane_min[c]    = val;
            end
        end
        if (ev == EV_ONSET)
            onsets_seen++;
        if (ev == EV_OFFSET)
            offsets_seen++;
        return ev;
    endfunction

    function automatic t_out predict_events(input t_in f);
        t_out                    r;
        logic [Q15_W+BASE_W-1:0] fl_prod;
        logic [Q15_W-1:0]        floor_lvl;
        fl_prod   = f.magnitude * base_cfg;
        floor_lvl = Q15_W'(fl_prod >> 15);
        r = '0;
        r.event_mag    = step_lane(0, f.magnitude, floor_lvl);
        r.active_mag   = lane_active[0];
        // channels beyond the configured count stay silent
        if (NUM_VEL_CHANNELS > 0) begin
            r.event_vel_0  = step_lane(1, abs_clip(f.velocity_0), floor_lvl);
            r.active_vel_0 = lane_active[1];
        end
        if (NUM_VEL_CHANNELS > 1) begin
            r.event_vel_1  = step_lane(2, abs_clip(f.velocity_1), floor_lvl);
            r.active_vel_1 = lane_active[2];
        end
        if (NUM_VEL_CHANNELS > 2) begin
            r.event_vel_2  = step_lane(3, abs_clip(f.velocity_2), floor_lvl);
            r.active_vel_2 = lane_active[3];
        end
        if (NUM_VEL_CHANNELS > 3) begin
            r.event_vel_3  = step_lane(4, abs_clip(f.velocity_3), floor_lvl);
            r.active_vel_3 = lane_active[4];
        end
        return r;
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 40);
        return $urandom_range(0, 3);
    endfunction

    function automatic t_in frame_of(input int mag, input int v0, input int v1,
                                     input int v2, input int v3);
        t_in f;
        f.magnitude  = Q15_W'(mag);
        f.velocity_0 = VEL_W'(v0);
        f.velocity_1 = VEL_W'(v1);
        f.velocity_2 = VEL_W'(v2);
        f.velocity_3 = VEL_W'(v3);
        return f;
    endfunction

    function automatic logic [VEL_W-1:0] vel_word(input int lvl, input bit wild);
        if (wild)
            return VEL_W'($urandom());
        return $urandom_range(0, 1) ? VEL_W'(-lvl) : VEL_W'(lvl);
    endfunction

    // mostly slow random walks so channels pass through onset and release,
    // with some fully random frames and some rail-to-rail jumps
    function automatic t_in random_frame();
        int  pick;
        bit  wild;
        t_in f;
        pick = $urandom_range(0, 19);
        wild = (pick < 3);
        for (int c = 0; c < MAX_LANES; c++) begin
            if (wild || $urandom_range(0, 24) == 0) begin
                walk_lvl[c] = $urandom_range(0, 32767);
            end else if (pick == 3) begin
                walk_lvl[c] = $urandom_range(0, 1) ? 32767 : 0;
            end else begin
                walk_lvl[c] += int'($urandom_range(0, 8000)) - 4000;
                if (walk_lvl[c] < 0)
                    walk_lvl[c] = 0;
                if (walk_lvl[c] > 32767)
                    walk_lvl[c] = 32767;
            end
        end
        f.magnitude  = wild ? Q15_W'($urandom()) : Q15_W'(walk_lvl[0]);
        f.velocity_0 = vel_word(walk_lvl[1], wild);
        f.velocity_1 = vel_word(walk_lvl[2], wild);
        f.velocity_2 = vel_word(walk_lvl[3], wild);
        f.velocity_3 = vel_word(walk_lvl[4], wild);
        return f;
    endfunction

    task automatic send_frame(input t_in frame);
        int gap;
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= frame;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic send_random(input int count);
        repeat (count) send_frame(random_frame());
    endtask

    // sender quiet, all results back, pipeline empty
    task automatic settle();
        i_valid <= 1'b0;
        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_regs(input logic [CFG_W-1:0] thr, input logic [CFG_W-1:0] base);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_THRESHOLD;
        i_cfg_data <= thr;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_BASE_RATIO;
        i_cfg_data <= base;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        thr_cfg  = thr[THR_W-1:0];
        base_cfg = base[BASE_W-1:0];
    endtask

    task automatic test_directed();
        send_frame(frame_of(0, 0, 0, 0, 0));
        send_frame(frame_of(32767, -32768, 32767, -32767, 16384));
        send_frame(frame_of(0, 0, -1, 1, -16384));
        send_frame(frame_of(0, 1, 2, 8193, 16385));
        // release level of 16385 at reset threshold is exactly 4096
        send_frame(frame_of(0, 0, 0, 8194, -4096));
        send_frame(frame_of(0, 0, 0, 0, -4095));
        send_frame(frame_of(20000, 0, 0, 0, 0));
        send_frame(frame_of(10000, 0, 0, 0, 0));
        send_frame(frame_of(4999, 0, 0, 0, 0));
        send_frame(frame_of(32767, 32767, 32767, 32767, 32767));
        send_frame(frame_of(32767, -32768, -32768, -32768, -32768));
        send_frame(frame_of(0, 0, 0, 0, 0));
        send_frame(frame_of(32767, 19660, 19661, -19661, -19660));
        send_frame(frame_of(32767, -1, 1, -32767, 32767));
        send_frame(frame_of(0, -32768, 0, -32768, 0));
        send_frame(frame_of(16384, 16384, -16384, 0, 32767));
        send_frame(frame_of(1, -2, 3, -4, 5));
        send_frame(frame_of(0, 0, 0, 0, 0));
        settle();
    endtask

    task automatic test_config_extremes();
        logic [CFG_W-1:0] thr_set  [6];
        logic [CFG_W-1:0] base_set [6];
        thr_set  = '{15'd3277, 15'd9830, 15'd0, 15'h7FFF, 15'h4000 | 15'd1000, 15'd8192};
        base_set = '{15'd16384, 15'd24576, 15'd0, 15'h7FFF, 15'd1, 15'd19661};
        for (int k = 0; k < 6; k++) begin
            write_regs(thr_set[k], base_set[k]);
            send_random(140);
            settle();
        end
    endtask

    task automatic test_random_traffic();
        for (int k = 0; k < 4; k++) begin
            write_regs(CFG_W'($urandom_range(3277, 9830)),
                       CFG_W'($urandom_range(16384, 24576)));
            tx_steady = (k == 1);
            rx_steady = (k == 2);
            send_random(150);
            settle();
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    task automatic test_backpressure();
        rx_hold   = 300;
        tx_steady = 1'b1;
        send_random(80);
        tx_steady = 1'b0;
        settle();
    endtask

    task automatic test_sender_pause();
        repeat (3) begin
            send_random(40);
            settle();
        end
    endtask

    // receiver: random stalls, plus a long hold when a test asks for one
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (rx_hold > 0) begin
                i_ready <= 1'b0;
                rx_hold--;
            end else if (stall_left > 0) begin
                i_ready <= 1'b0;
                stall_left--;
            end else begin
                i_ready <= 1'b1;
                if (!rx_steady && $urandom_range(0, 4) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready) begin
            pending_events.push_back(predict_events(i_data));
            frames_sent++;
        end
    end

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (pending_events.size() == 0) begin
                $error("result transaction with nothing outstanding: %h", o_data);
                fail_count++;
            end else begin
                want = pending_events.pop_front();
                check_field("event_mag",    want.event_mag,    o_data.event_mag);
                check_field("event_vel_0",  want.event_vel_0,  o_data.event_vel_0);
                check_field("event_vel_1",  want.event_vel_1,  o_data.event_vel_1);
                check_field("event_vel_2",  want.event_vel_2,  o_data.event_vel_2);
                check_field("event_vel_3",  want.event_vel_3,  o_data.event_vel_3);
                check_field("active_mag",   want.active_mag,   o_data.active_mag);
                check_field("active_vel_0", want.active_vel_0, o_data.active_vel_0);
                check_field("active_vel_1", want.active_vel_1, o_data.active_vel_1);
                check_field("active_vel_2", want.active_vel_2, o_data.active_vel_2);
                check_field("active_vel_3", want.active_vel_3, o_data.active_vel_3);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_config_extremes();
        test_random_traffic();
        test_backpressure();
        test_sender_pause();

        settle();
        if (pending_events.size() != 0) begin
            $error("%0d expected results never arrived", pending_events.size());
            fail_count++;
        end
        $display("Sent %0d frames, checked %0d results over 11 register settings",
                 frames_sent, results_seen);
        $display("Predicted %0d onsets and %0d offsets across all channels",
                 onsets_seen, offsets_seen);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
